/* rtl/fsd_pkg.sv */
`timescale 1ns / 1ps
// Fall and stomp detector package: default widths, mode and phase codes,
// configuration register indexes. No dependencies.
package fsd_pkg;

    localparam int unsigned TIME_WIDTH_DEF   = 32;
    localparam int unsigned SAMPLE_WIDTH_DEF = 16;
    localparam int unsigned REG_IDX_W        = 3;

    // Detection mode, also the mode_now result code.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FALL  = 2'd1,
        MODE_STOMP = 2'd2
    } t_mode;

    // Stomp sequence phase while armed.
    typedef enum logic [1:0] {
        PH_WAIT     = 2'd0,
        PH_ONE_MORE = 2'd1,
        PH_DONE     = 2'd2
    } t_phase;

    // Configuration register indexes (byte address = index * word bytes).
    typedef enum logic [REG_IDX_W-1:0] {
        REG_SENSOR_MODE   = 3'd0,
        REG_FALL_THR      = 3'd1,
        REG_FALL_TIME     = 3'd2,
        REG_RECOVER_TIME  = 3'd3,
        REG_STOMP_RISE    = 3'd4,
        REG_STOMP_IMPACT  = 3'd5,
        REG_STOMP_TIMEOUT = 3'd6
    } t_reg_idx;

endpackage

/* rtl/fall_and_stomp_detector_top.sv */
`timescale 1ns / 1ps
// Fall and stomp detector top level: APB config registers, detection logic,
// output register with skid stage. Depends on fsd_pkg.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+------------------------------
//  sample in | in        | i_in_valid / o_in_ready   | i_mag_x, i_accel_z, i_now_us
//  result    | out       | o_out_valid / i_out_ready | o_fall_flag, o_stomp_flag,
//            |           |                           | o_mode_now
//  config    | in        | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One sample per cycle. The whole step is a few compares and one wrapping
// subtract per timer, evaluated from the sample ports and the state registers
// in the accept cycle; the result is written at the accepting edge, to the
// output register or, while that holds an untaken result, to the skid stage.
// A two-deep output (output register plus skid) keeps o_in_ready registered:
// a request is taken while a result waits, and only a full skid stage stalls
// the input. Reset (synchronous, active low) clears config, mode and timers.
module fall_and_stomp_detector_top
    import fsd_pkg::*;
#(
    parameter int unsigned TIME_WIDTH   = TIME_WIDTH_DEF,
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int unsigned DATA_W      = (TIME_WIDTH > 32) ? 64 : 32,
    localparam int unsigned ADDR_LSB    = $clog2(DATA_W / 8),
    localparam int unsigned ADDR_W      = ADDR_LSB + REG_IDX_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_mag_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_z,
    input  logic        [TIME_WIDTH-1:0]   i_now_us,

    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_fall_flag,
    output logic                           o_stomp_flag,
    output logic        [1:0]              o_mode_now,

    // APB-style configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic        [ADDR_W-1:0]       paddr,
    input  logic        [DATA_W-1:0]       pwdata,
    output logic        [DATA_W-1:0]       prdata,
    output logic                           pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                           r_sensor_mode;   // 1 = calibrate
    logic signed [SAMPLE_WIDTH-1:0] r_fall_thr;
    logic        [TIME_WIDTH-1:0]   r_fall_time;
    logic        [TIME_WIDTH-1:0]   r_recover_time;
    logic signed [SAMPLE_WIDTH-1:0] r_stomp_rise;
    logic signed [SAMPLE_WIDTH-1:0] r_stomp_impact;
    logic        [TIME_WIDTH-1:0]   r_stomp_limit;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    // Low address bits below the word size are ignored.
    assign cfg_idx = paddr[ADDR_W-1:ADDR_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_mode   <= 1'b0;
            r_fall_thr      <= '0;
            r_fall_time     <= '0;
            r_recover_time  <= '0;
            r_stomp_rise    <= '0;
            r_stomp_impact  <= '0;
            r_stomp_limit   <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SENSOR_MODE:   r_sensor_mode   <= pwdata[0];
                REG_FALL_THR:      r_fall_thr      <= pwdata[SAMPLE_WIDTH-1:0];
                REG_FALL_TIME:     r_fall_time     <= pwdata[TIME_WIDTH-1:0];
                REG_RECOVER_TIME:  r_recover_time  <= pwdata[TIME_WIDTH-1:0];
                REG_STOMP_RISE:    r_stomp_rise    <= pwdata[SAMPLE_WIDTH-1:0];
                REG_STOMP_IMPACT:  r_stomp_impact  <= pwdata[SAMPLE_WIDTH-1:0];
                REG_STOMP_TIMEOUT: r_stomp_limit   <= pwdata[TIME_WIDTH-1:0];
                default: ;         // unmapped slot, write dropped
            endcase
        end
    end

    // Read back: raw register bits, zero-extended.
    always_comb begin
        unique case (cfg_idx)
            REG_SENSOR_MODE:   prdata = DATA_W'(r_sensor_mode);
            REG_FALL_THR:      prdata = DATA_W'($unsigned(r_fall_thr));
            REG_FALL_TIME:     prdata = DATA_W'(r_fall_time);
            REG_RECOVER_TIME:  prdata = DATA_W'(r_recover_time);
            REG_STOMP_RISE:    prdata = DATA_W'($unsigned(r_stomp_rise));
            REG_STOMP_IMPACT:  prdata = DATA_W'($unsigned(r_stomp_impact));
            REG_STOMP_TIMEOUT: prdata = DATA_W'(r_stomp_limit);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Detection state
    // ------------------------------------------------------------------
    t_mode                  r_mode,          n_mode;
    t_phase                 r_phase,         n_phase;
    logic                   r_fall_pend,     n_fall_pend;
    logic                   r_rec_pend,      n_rec_pend;
    logic [TIME_WIDTH-1:0]  r_fall_start,    n_fall_start;
    logic [TIME_WIDTH-1:0]  r_rec_start,     n_rec_start;
    logic [TIME_WIDTH-1:0]  r_stomp_start,   n_stomp_start;

    logic in_acc;
    logic out_take;

    // Elapsed times wrap modulo 2^TIME_WIDTH.
    logic [TIME_WIDTH-1:0] fall_elapsed;
    logic [TIME_WIDTH-1:0] rec_elapsed;
    logic [TIME_WIDTH-1:0] stomp_elapsed;
    logic fall_expired, rec_expired, stomp_expired;
    logic x_below, x_above, z_rise, z_impact;

    assign fall_elapsed  = i_now_us - r_fall_start;
    assign rec_elapsed   = i_now_us - r_rec_start;
    assign stomp_elapsed = i_now_us - r_stomp_start;
    assign fall_expired  = fall_elapsed  > r_fall_time;
    assign rec_expired   = rec_elapsed   > r_recover_time;
    assign stomp_expired = stomp_elapsed > r_stomp_limit;

    assign x_below  = i_mag_x <  r_fall_thr;
    assign x_above  = i_mag_x >  r_fall_thr;
    assign z_rise   = i_accel_z <= r_stomp_rise;
    assign z_impact = i_accel_z >= r_stomp_impact;

    // Next state
    always_comb begin
        n_mode        = r_mode;
        n_phase       = r_phase;
        n_fall_pend   = r_fall_pend;
        n_rec_pend    = r_rec_pend;
        n_fall_start  = r_fall_start;
        n_rec_start   = r_rec_start;
        n_stomp_start = r_stomp_start;
        if (!r_sensor_mode) begin
            unique case (r_mode)
                MODE_FALL: begin
                    if (x_above) begin
                        if (r_rec_pend) begin
                            if (rec_expired) begin
                                n_fall_pend = 1'b0;
                                n_mode      = MODE_IDLE;
                            end
                        end else begin
                            n_rec_pend  = 1'b1;
                            n_rec_start = i_now_us;
                        end
                    end else begin
                        // equal to threshold also cancels recovery
                        n_rec_pend = 1'b0;
                    end
                end
                MODE_STOMP: begin
                    unique case (r_phase)
                        PH_WAIT: begin
                            if (stomp_expired) begin
                                n_mode = MODE_IDLE;
                            end else if (z_impact) begin
                                n_phase = PH_ONE_MORE;
                            end
                        end
                        PH_ONE_MORE: n_phase = PH_DONE;
                        default: begin
                            // done (or stray code): back to idle
                            n_stomp_start = '0;
                            n_mode        = MODE_IDLE;
                        end
                    endcase
                end
                default: begin
                    // idle; a stray mode code behaves the same
                    n_mode = MODE_IDLE;
                    if (x_below) begin
                        if (r_fall_pend) begin
                            if (fall_expired) begin
                                n_rec_pend = 1'b0;
                                n_mode     = MODE_FALL;
                            end
                        end else begin
                            n_fall_pend  = 1'b1;
                            n_fall_start = i_now_us;
                        end
                    end else begin
                        if (z_rise) begin
                            n_mode        = MODE_STOMP;
                            n_stomp_start = i_now_us;
                            n_phase       = PH_WAIT;
                        end
                        n_fall_pend = 1'b0;
                    end
                end
            endcase
        end
    end

    // Result flags for the sample being accepted
    logic n_fall_flag;
    logic n_stomp_flag;

    always_comb begin
        n_fall_flag  = 1'b0;
        n_stomp_flag = 1'b0;
        if (!r_sensor_mode) begin
            unique case (r_mode)
                MODE_FALL: n_fall_flag = !(x_above && r_rec_pend && rec_expired);
                MODE_STOMP: begin
                    unique case (r_phase)
                        PH_WAIT:     n_stomp_flag = !stomp_expired && z_impact;
                        PH_ONE_MORE: n_stomp_flag = 1'b1;
                        default:     n_stomp_flag = 1'b0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_phase       <= PH_WAIT;
            r_fall_pend   <= 1'b0;
            r_rec_pend    <= 1'b0;
            r_fall_start  <= '0;
            r_rec_start   <= '0;
            r_stomp_start <= '0;
        end else if (in_acc) begin
            r_mode        <= n_mode;
            r_phase       <= n_phase;
            r_fall_pend   <= n_fall_pend;
            r_rec_pend    <= n_rec_pend;
            r_fall_start  <= n_fall_start;
            r_rec_start   <= n_rec_start;
            r_stomp_start <= n_stomp_start;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid stage
    // ------------------------------------------------------------------
    logic       r_out_vld;
    logic       r_skid_vld;
    logic       r_out_fall,  r_skid_fall;
    logic       r_out_stomp, r_skid_stomp;
    logic [1:0] r_out_mode,  r_skid_mode;

    assign o_in_ready = !r_skid_vld;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_take   = r_out_vld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_take) begin
            if (r_skid_vld) begin
                r_skid_vld <= 1'b0;     // skid moves up, no accept this cycle
            end else begin
                r_out_vld  <= in_acc;
            end
        end else if (in_acc) begin
            if (r_out_vld) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_skid_vld) begin
            r_out_fall  <= r_skid_fall;
            r_out_stomp <= r_skid_stomp;
            r_out_mode  <= r_skid_mode;
        end else if (in_acc && (out_take || !r_out_vld)) begin
            r_out_fall  <= n_fall_flag;
            r_out_stomp <= n_stomp_flag;
            r_out_mode  <= n_mode;
        end
        if (in_acc && r_out_vld && !out_take) begin
            r_skid_fall  <= n_fall_flag;
            r_skid_stomp <= n_stomp_flag;
            r_skid_mode  <= n_mode;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_fall_flag  = r_out_fall;
    assign o_stomp_flag = r_out_stomp;
    assign o_mode_now   = r_out_mode;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a result while output register is empty");

    a_fallen_keeps_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_FALL) |-> r_fall_pend)
        else $error("fallen mode without fall pending");

    a_calib_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_sensor_mode) |=> $stable(r_mode) && $stable(r_phase))
        else $error("calibrate sample changed detection state");

    a_stomp_only_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_stomp_flag) |-> (r_mode == MODE_STOMP))
        else $error("stomp flag outside stomp mode");

    a_one_more_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_sensor_mode && r_mode == MODE_STOMP && r_phase == PH_ONE_MORE)
        |=> (r_phase == PH_DONE))
        else $error("second stomp sample did not finish the sequence");

endmodule
